FILE: src/dd_odo_pkg.sv
// constants for the differential drive odometry block
// cordic gain and arctangent table, reciprocal of two pi, register indexes
// no dependencies
`timescale 1ns / 1ps

package dd_odo_pkg;

  localparam logic [0:0] REG_WHEEL_BASE    = 1'd0;
  localparam logic [0:0] REG_SAMPLE_PERIOD = 1'd1;

  localparam logic signed [31:0] CORDIC_K   = 32'sd163008218;
  localparam logic signed [31:0] INV2PI_Q32 = 32'sd683565276;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/differential_drive_odometry.sv
// differential drive wheel odometry: pose kept in x, y and heading
// uses dd_odo_pkg; one shared multiplier, one cordic step unit, one radix-2 divider
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: left_speed, right_speed; tuser: slip
// m_axis    out  m_axis_tvalid/tready       tdata: pos_x, pos_y, heading; tuser: saturated
// cfg       in   cfg_we_i                   cfg_index_i, cfg_data_i
//
// a straight item runs one cordic pass and the rotation products; a turning item
// runs two cordic passes and three divisions in the bit-serial divider (DIV_W = 41
// at the default ANGLE_BITS). a slipped item skips the arithmetic and goes to the output.
// reset clears the pose and loads the register defaults; no clearing pass.
// a new item is taken while the previous result waits at the output register.
`timescale 1ns / 1ps

module differential_drive_odometry #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // left_speed, right_speed
  input  logic [0:0]  s_axis_tuser,  // slip
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // pos_x, pos_y, heading
  output logic [0:0]  m_axis_tuser,  // saturated
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import dd_odo_pkg::*;

  localparam int AB    = ANGLE_BITS;
  localparam int K_SH  = 48 - AB;
  localparam int DIV_W = (14 + AB > 41) ? 14 + AB : 41;
  localparam int CW    = $clog2(DIV_W);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CINIT = 5'd1;
  localparam logic [4:0] S_CITER = 5'd2;
  localparam logic [4:0] S_CEND  = 5'd3;
  localparam logic [4:0] S_STR1  = 5'd4;
  localparam logic [4:0] S_STR2  = 5'd5;
  localparam logic [4:0] S_STR3  = 5'd6;
  localparam logic [4:0] S_STR4  = 5'd7;
  localparam logic [4:0] S_PHI1  = 5'd8;
  localparam logic [4:0] S_PHI2  = 5'd9;
  localparam logic [4:0] S_PHI3  = 5'd10;
  localparam logic [4:0] S_PHI4  = 5'd11;
  localparam logic [4:0] S_DIV   = 5'd12;
  localparam logic [4:0] S_TRN1  = 5'd13;
  localparam logic [4:0] S_TRN2  = 5'd14;
  localparam logic [4:0] S_TRN3  = 5'd15;
  localparam logic [4:0] S_TRN4  = 5'd16;
  localparam logic [4:0] S_TRN5  = 5'd17;
  localparam logic [4:0] S_TRN6  = 5'd18;
  localparam logic [4:0] S_UPD   = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  localparam logic [1:0] OP_PHI = 2'd0;
  localparam logic [1:0] OP_DX  = 2'd1;
  localparam logic [1:0] OP_DY  = 2'd2;

  logic [4:0]  st_q;
  logic [15:0] wb_q, sp_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [AB-1:0] pose_h_q;

  logic signed [15:0] lv_q, rv_q;
  logic [15:0] a_q, ad_q;
  logic        dneg_q, deq0_q;

  logic [AB-1:0] cang_q;
  logic          cpass_q;
  logic [1:0]    quad_q;
  logic [4:0]    ci_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [31:0] c1_q, s1_q, ds_q, dc_q;

  logic signed [65:0] prod_q;
  logic signed [33:0] num_q;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;

  logic [DIV_W-1:0] dn_q;
  logic [15:0]      dr_q, dv_q;
  logic [CW-1:0]    dcnt_q;
  logic [1:0]       dop_q;
  logic             dsgn_q;

  logic signed [41:0] dx_q, dy_q;
  logic               sat_q;

  logic        m_valid_q;
  logic signed [31:0] mx_q, my_q;
  logic [15:0] mh_q;
  logic        msat_q;

  logic        in_acc;
  logic        out_ld;
  logic signed [16:0] dsum, ddif;
  logic [16:0] dabs;
  logic [31:0] a32;
  logic signed [31:0] xs, ys, cos_v, sin_v;
  logic [16:0] rem17;
  logic        ge;
  logic [65:0] pmag;
  logic [63:0] phi_num, trn_num;
  logic [AB-1:0] phi_v;
  logic signed [41:0] qsig;
  logic signed [42:0] sx, sy;
  logic [AB+15:0] hcat;

  function automatic logic signed [41:0] rnd36(input logic signed [65:0] p);
    logic [65:0] m;
    logic [65:0] q;
    m = p[65] ? 66'(-p) : 66'(p);
    q = (m + (66'd1 << 35)) >> 36;
    return p[65] ? -$signed({1'b0, q[40:0]}) : $signed({1'b0, q[40:0]});
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fffffff;
    if (v < -43'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_ld = (st_q == S_OUT) && (!m_valid_q || m_axis_tready);

  assign ddif = $signed({s_axis_tdata[31], s_axis_tdata[31:16]})
              - $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
  assign dabs = ddif[16] ? 17'(-ddif) : 17'(ddif);
  assign dsum = 17'(lv_q) + 17'(rv_q);

  assign a32 = 32'(cang_q) << (32 - AB);
  assign xs  = cx_q >>> ci_q;
  assign ys  = cy_q >>> ci_q;

  always_comb begin
    case (quad_q)
      2'd0: begin cos_v = cx_q;  sin_v = cy_q;  end
      2'd1: begin cos_v = -cy_q; sin_v = cx_q;  end
      2'd2: begin cos_v = -cx_q; sin_v = -cy_q; end
      default: begin cos_v = cy_q; sin_v = -cx_q; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_PHI1: begin mul_a = 34'($signed({1'b0, ad_q})); mul_b = 32'($signed({1'b0, sp_q})); end
      S_PHI2: begin mul_a = $signed({2'b0, prod_q[31:0]}); mul_b = INV2PI_Q32; end
      S_STR1: begin mul_a = 34'(lv_q); mul_b = 32'($signed({1'b0, sp_q})); end
      S_STR2: begin mul_a = prod_q[33:0]; mul_b = c1_q; end
      S_STR3: begin mul_a = num_q; mul_b = s1_q; end
      S_TRN1: begin mul_a = 34'($signed({1'b0, a_q})); mul_b = 32'(dsum); end
      S_TRN2: begin mul_a = prod_q[33:0]; mul_b = ds_q; end
      S_TRN4: begin mul_a = num_q; mul_b = dc_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rem17 = {dr_q, dn_q[DIV_W-1]};
  assign ge    = rem17 >= {1'b0, dv_q};

  assign pmag    = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
  assign phi_num = (prod_q[63:0] + (64'(a_q) << (K_SH - 1))) >> K_SH;
  assign trn_num = (pmag[63:0] + (64'(ad_q) << 20)) >> 21;
  assign phi_v   = dneg_q ? AB'(-dn_q[AB-1:0]) : dn_q[AB-1:0];
  assign qsig    = dsgn_q ? -$signed({1'b0, dn_q[40:0]}) : $signed({1'b0, dn_q[40:0]});

  assign sx   = 43'(pose_x_q) + 43'(dx_q);
  assign sy   = 43'(pose_y_q) + 43'(dy_q);
  assign hcat = {pose_h_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 16'd300;
      sp_q <= 16'd655;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WHEEL_BASE) wb_q <= cfg_data_i;
      else wb_q <= wb_q;
      if (cfg_index_i == REG_SAMPLE_PERIOD) sp_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      pose_h_q  <= '0;
      m_valid_q <= 1'b0;
      sat_q     <= 1'b0;
      lv_q      <= '0;
      rv_q      <= '0;
      a_q       <= '0;
      ad_q      <= '0;
      dneg_q    <= 1'b0;
      deq0_q    <= 1'b0;
      cang_q    <= '0;
      cpass_q   <= 1'b0;
      quad_q    <= '0;
      ci_q      <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      cz_q      <= '0;
      c1_q      <= '0;
      s1_q      <= '0;
      ds_q      <= '0;
      dc_q      <= '0;
      num_q     <= '0;
      dn_q      <= '0;
      dr_q      <= '0;
      dv_q      <= '0;
      dcnt_q    <= '0;
      dop_q     <= OP_PHI;
      dsgn_q    <= 1'b0;
      dx_q      <= '0;
      dy_q      <= '0;
      mx_q      <= '0;
      my_q      <= '0;
      mh_q      <= '0;
      msat_q    <= 1'b0;
    end else begin
      if (out_ld) m_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            lv_q   <= $signed(s_axis_tdata[15:0]);
            rv_q   <= $signed(s_axis_tdata[31:16]);
            a_q    <= (wb_q == 16'd0) ? 16'd1 : wb_q;
            ad_q   <= dabs[15:0];
            dneg_q <= ddif[16];
            deq0_q <= (ddif == 17'sd0);
            cang_q <= pose_h_q;
            cpass_q <= 1'b0;
            sat_q  <= 1'b0;
            st_q   <= s_axis_tuser[0] ? S_OUT : S_CINIT;
          end
        end
        S_CINIT: begin
          cx_q   <= CORDIC_K;
          cy_q   <= '0;
          cz_q   <= $signed({2'b0, a32[29:0]});
          quad_q <= a32[31:30];
          ci_q   <= '0;
          st_q   <= S_CITER;
        end
        S_CITER: begin
          if (!cz_q[31]) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - $signed(atan_val(ci_q));
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + $signed(atan_val(ci_q));
          end
          ci_q <= ci_q + 5'd1;
          if (ci_q == 5'(CORDIC_STEPS - 1)) st_q <= S_CEND;
        end
        S_CEND: begin
          if (!cpass_q) begin
            c1_q <= cos_v;
            s1_q <= sin_v;
            st_q <= deq0_q ? S_STR1 : S_PHI1;
          end else begin
            ds_q <= sin_v - s1_q;
            dc_q <= c1_q - cos_v;
            st_q <= S_TRN1;
          end
        end
        S_STR1: st_q <= S_STR2;
        S_STR2: begin
          num_q <= prod_q[33:0];
          st_q  <= S_STR3;
        end
        S_STR3: begin
          dx_q <= rnd36(prod_q);
          st_q <= S_STR4;
        end
        S_STR4: begin
          dy_q <= rnd36(prod_q);
          st_q <= S_UPD;
        end
        S_PHI1: st_q <= S_PHI2;
        S_PHI2: st_q <= S_PHI3;
        S_PHI3: begin
          dn_q   <= phi_num[DIV_W-1:0];
          dv_q   <= a_q;
          dr_q   <= '0;
          dcnt_q <= '0;
          dop_q  <= OP_PHI;
          st_q   <= S_DIV;
        end
        S_DIV: begin
          dr_q   <= ge ? 16'(rem17 - {1'b0, dv_q}) : rem17[15:0];
          dn_q   <= {dn_q[DIV_W-2:0], ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == CW'(DIV_W - 1)) begin
            case (dop_q)
              OP_PHI:  st_q <= S_PHI4;
              OP_DX:   st_q <= S_TRN4;
              default: st_q <= S_TRN6;
            endcase
          end
        end
        S_PHI4: begin
          cang_q  <= cang_q + phi_v;
          cpass_q <= 1'b1;
          st_q    <= S_CINIT;
        end
        S_TRN1: st_q <= S_TRN2;
        S_TRN2: begin
          num_q <= prod_q[33:0];
          st_q  <= S_TRN3;
        end
        S_TRN3, S_TRN5: begin
          dn_q   <= trn_num[DIV_W-1:0];
          dv_q   <= ad_q;
          dr_q   <= '0;
          dcnt_q <= '0;
          dsgn_q <= prod_q[65] ^ dneg_q;
          dop_q  <= (st_q == S_TRN3) ? OP_DX : OP_DY;
          st_q   <= S_DIV;
        end
        S_TRN4: begin
          dx_q <= qsig;
          st_q <= S_TRN5;
        end
        S_TRN6: begin
          dy_q <= qsig;
          st_q <= S_UPD;
        end
        S_UPD: begin
          pose_x_q <= clamp32(sx);
          pose_y_q <= clamp32(sy);
          sat_q    <= (sx != 43'(clamp32(sx))) || (sy != 43'(clamp32(sy)));
          if (!deq0_q) pose_h_q <= cang_q;
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ld) begin
            mx_q   <= pose_x_q;
            my_q   <= pose_y_q;
            mh_q   <= 16'(hcat >> AB);
            msat_q <= sat_q;
            st_q   <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {mh_q, my_q, mx_q};
  assign m_axis_tuser  = msat_q;

endmodule

FILE: bench/differential_drive_odometry_test.sv
// testbench for differential_drive_odometry: directed table then random wheel speed items
// pose predicted in the bench with its own cordic and rounding divisions, checked field by field
// depends on dd_odo_pkg and differential_drive_odometry
`timescale 1ns / 1ps

module differential_drive_odometry_test;
  import dd_odo_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hd;
    logic               sat;
  } pose_t;

  typedef struct {
    logic signed [15:0] lft;
    logic signed [15:0] rgt;
    logic               slp;
    logic               typed;
    pose_t              pose;
  } row_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int N_STEPS = 16;
  localparam longint ATAN_Q30 [N_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  differential_drive_odometry dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] track_x = 0, track_y = 0;
  logic [15:0]        track_hd = 0;
  logic [15:0]        base_mm = 16'd300, period = 16'd655;

  pose_t pose_q[$];
  logic  cur_typed = 1'b0;
  pose_t cur_pose = '0;
  int    errors = 0, n_in = 0, n_out = 0, n_sat = 0, n_slip = 0, n_turn = 0;
  bit    jitter = 1'b1;
  bit    held = 1'b0;
  int    hold = 0;
  int    idle_cycles = 0;

  function automatic void trig(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, nx;
    x = CORDIC_K;
    y = 0;
    z = longint'({ang[13:0], 16'h0});
    for (int i = 0; i < N_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_Q30[i];
      end
      x = nx;
    end
    case (ang[15:14])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint round_div(input longint n, input longint unsigned d);
    longint unsigned m, q;
    m = n < 0 ? longint'(-n) : n;
    q = (m + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clip(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin sat = 1'b1; return 32'sh7fffffff; end
    if (v < -64'sd2147483648) begin sat = 1'b1; return 32'sh80000000; end
    return v[31:0];
  endfunction

  function automatic pose_t advance_pose(input logic signed [15:0] lft,
                                         input logic signed [15:0] rgt, input logic slp);
    longint a, t, d, ad, dx, dy, c1, s1, c2, s2, num;
    longint unsigned mag, den;
    logic [15:0] phi;
    logic sat;
    pose_t p;
    sat = 1'b0;
    if (!slp) begin
      a = base_mm == 0 ? 1 : base_mm;
      t = period;
      d = longint'(rgt) - longint'(lft);
      trig(track_hd, c1, s1);
      if (d == 0) begin
        dx = round_div(longint'(lft) * t * c1, 64'd1 << 36);
        dy = round_div(longint'(lft) * t * s1, 64'd1 << 36);
      end else begin
        ad = d < 0 ? -d : d;
        mag = longint'(ad) * t * 64'd683565276;
        den = longint'(a) << 32;
        phi = 16'((mag + den / 2) / den);
        if (d < 0) phi = -phi;
        trig(track_hd + phi, c2, s2);
        num = a * (longint'(lft) + longint'(rgt));
        if (d < 0) num = -num;
        dx = round_div(num * (s2 - s1), ad << 21);
        dy = round_div(num * (c1 - c2), ad << 21);
        track_hd = track_hd + phi;
      end
      track_x = clip(longint'(track_x) + dx, sat);
      track_y = clip(longint'(track_y) + dy, sat);
    end
    p.x = track_x;
    p.y = track_y;
    p.hd = track_hd;
    p.sat = sat;
    return p;
  endfunction

  always @(posedge clk_i) begin
    pose_t p;
    if (s_axis_tvalid && s_axis_tready) begin
      p = advance_pose(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser[0]);
      pose_q.insert(pose_q.size(), cur_typed ? cur_pose : p);
      n_in++;
      if (s_axis_tuser[0]) n_slip++;
      else if (s_axis_tdata[15:0] != s_axis_tdata[31:16]) n_turn++;
    end
  end

  always @(posedge clk_i) begin
    pose_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (pose_q.size() == 0) begin
        $error("item with no expectation waiting");
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (m_axis_tuser[0]) n_sat++;
        if (m_axis_tdata[31:0] !== e.x) begin
          $error("pos_x expected %0d got %0d", e.x, $signed(m_axis_tdata[31:0])); errors++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $error("pos_y expected %0d got %0d", e.y, $signed(m_axis_tdata[63:32])); errors++;
        end
        if (m_axis_tdata[79:64] !== e.hd) begin
          $error("heading expected %0d got %0d", e.hd, m_axis_tdata[79:64]); errors++;
        end
        if (m_axis_tuser[0] !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, m_axis_tuser[0]); errors++;
        end
      end
    end
  end

  // receiver, with one long hold-off once 100 items have gone in
  always @(posedge clk_i) begin
    if (hold > 0) begin
      hold <= hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && n_in >= 100) begin
      held <= 1'b1;
      hold <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= jitter ? ($urandom_range(99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("differential_drive_odometry_test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic signed [15:0] lft, input logic signed [15:0] rgt,
                           input logic slp, input logic typed, input pose_t pose);
    while (jitter && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rgt, lft};
    s_axis_tuser <= slp;
    cur_typed <= typed;
    cur_pose <= pose;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pose_q.size() == 0);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WHEEL_BASE) base_mm = val;
    else period = val;
  endtask

  task automatic random_item(input int straight_pct);
    logic signed [15:0] l, r;
    int k;
    k = $urandom_range(99);
    l = 16'($urandom);
    r = 16'($urandom);
    if ($urandom_range(9) == 0) l = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if ($urandom_range(9) == 0) r = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if (k < straight_pct) r = l;
    else if (k < straight_pct + 15) r = l + $signed(16'($urandom_range(8))) - 16'sd4;
    send_item(l, r, $urandom_range(9) == 0, 1'b0, '0);
  endtask

  row_t table_rows [14];
  logic [15:0] cfg_list [7][2];

  initial begin
    table_rows = '{
      '{16'sd0, 16'sd0, 1'b1, 1'b1, '0},
      '{16'sd0, 16'sd0, 1'b0, 1'b1, '0},
      '{16'sd32767, 16'sd32767, 1'b0, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 1'b0, 1'b0, '0},
      '{16'sd0, 16'sd1, 1'b0, 1'b0, '0},
      '{16'sd1, 16'sd0, 1'b0, 1'b0, '0},
      '{16'sd100, -16'sd100, 1'b0, 1'b0, '0},
      '{16'sd500, 16'sd700, 1'b0, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 1'b1, 1'b0, '0},
      '{-16'sd1, -16'sd1, 1'b0, 1'b0, '0},
      '{-16'sd300, 16'sd1200, 1'b0, 1'b0, '0},
      '{16'sd2000, 16'sd2000, 1'b0, 1'b0, '0}};
    cfg_list = '{
      '{16'd1, 16'd65535}, '{16'd0, 16'd1}, '{16'd65535, 16'd0}, '{16'd65535, 16'd65535},
      '{16'd0, 16'd0}, '{16'd0, 16'd0}, '{16'd0, 16'd0}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_item(table_rows[i].lft, table_rows[i].rgt, table_rows[i].slp,
                table_rows[i].typed, table_rows[i].pose);

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_WHEEL_BASE, ph >= 4 ? 16'($urandom_range(2000, 40)) : cfg_list[ph][0]);
      write_reg(REG_SAMPLE_PERIOD, ph >= 4 ? 16'($urandom) : cfg_list[ph][1]);
      jitter = (ph != 2);
      for (int n = 0; n < (ph == 3 ? 330 : 200); n++) begin
        if (ph == 3 && n < 300)
          send_item(16'sd32767, $urandom_range(19) == 0 ? 16'sd30000 : 16'sd32767,
                    1'b0, 1'b0, '0);
        else
          random_item(ph == 3 ? 80 : 35);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pose_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("%0d items sent, %0d results checked: %0d turns, %0d slips, %0d clipped",
             n_in, n_out, n_turn, n_slip, n_sat);
    $display("register settings covered zero base, zero period and both extremes");
    if (errors == 0 && n_out == n_in) $display("differential_drive_odometry_test passed");
    else $display("differential_drive_odometry_test failed");
    $finish;
  end

endmodule
